### rtl/mwdds_pkg.sv
package mwdds_pkg;

  // Address bits of the configuration port: seven word registers.
  localparam int unsigned CFG_AW = 5;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [2:0] {
    MODE_SINE     = 3'd0,
    MODE_SQUARE   = 3'd1,
    MODE_TRIANGLE = 3'd2,
    MODE_SAWTOOTH = 3'd3,
    MODE_CHIRP    = 3'd4,
    MODE_IMPULSE  = 3'd5,
    MODE_DC       = 3'd6
  } wave_mode_e;

  typedef enum logic [2:0] {
    REG_WAVEFORM_MODE     = 3'd0,
    REG_PHASE_STEP        = 3'd1,
    REG_PHASE_OFFSET      = 3'd2,
    REG_AMPLITUDE         = 3'd3,
    REG_DC_OFFSET         = 3'd4,
    REG_CHIRP_STEP_CHANGE = 3'd5,
    REG_SAMPLE_COUNT      = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    wave_mode_e         waveform_mode;
    logic [31:0]        phase_step;
    logic [31:0]        phase_offset;
    logic signed [15:0] amplitude;
    logic signed [15:0] dc_offset;
    logic signed [31:0] chirp_step_change;
    logic [20:0]        sample_count;
  } cfg_t;

  // Quarter-wave sine entry in Q1.15 from an angle in Q30 radians. Taylor
  // series in Horner form; only ever evaluated on constants.
  function automatic logic [14:0] sine_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    return v[14:0];
  endfunction

endpackage

### rtl/mwdds_regs.sv
module mwdds_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mwdds_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output mwdds_pkg::cfg_t                cfg_o
);

  localparam mwdds_pkg::cfg_t CFG_RESET = '{
    waveform_mode:     mwdds_pkg::MODE_SINE,
    phase_step:        32'd0,
    phase_offset:      32'd0,
    amplitude:         16'sd0,
    dc_offset:         16'sd0,
    chirp_step_change: 32'sd0,
    sample_count:      21'd1024
  };

  mwdds_pkg::cfg_t  cfg_q, cfg_d;
  mwdds_pkg::cfg_reg_e reg_sel;
  logic             wr_en;

  assign reg_sel = mwdds_pkg::cfg_reg_e'(paddr[mwdds_pkg::CFG_AW-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_sel)
        mwdds_pkg::REG_WAVEFORM_MODE: begin
          cfg_d.waveform_mode = mwdds_pkg::wave_mode_e'(pwdata[2:0]);
        end
        mwdds_pkg::REG_PHASE_STEP:        cfg_d.phase_step        = pwdata;
        mwdds_pkg::REG_PHASE_OFFSET:      cfg_d.phase_offset      = pwdata;
        mwdds_pkg::REG_AMPLITUDE:         cfg_d.amplitude         = pwdata[15:0];
        mwdds_pkg::REG_DC_OFFSET:         cfg_d.dc_offset         = pwdata[15:0];
        mwdds_pkg::REG_CHIRP_STEP_CHANGE: cfg_d.chirp_step_change = pwdata;
        mwdds_pkg::REG_SAMPLE_COUNT:      cfg_d.sample_count      = pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_sel)
      mwdds_pkg::REG_WAVEFORM_MODE:     prdata = {29'd0, cfg_q.waveform_mode};
      mwdds_pkg::REG_PHASE_STEP:        prdata = cfg_q.phase_step;
      mwdds_pkg::REG_PHASE_OFFSET:      prdata = cfg_q.phase_offset;
      mwdds_pkg::REG_AMPLITUDE:         prdata = {16'd0, cfg_q.amplitude};
      mwdds_pkg::REG_DC_OFFSET:         prdata = {16'd0, cfg_q.dc_offset};
      mwdds_pkg::REG_CHIRP_STEP_CHANGE: prdata = cfg_q.chirp_step_change;
      mwdds_pkg::REG_SAMPLE_COUNT:      prdata = {11'd0, cfg_q.sample_count};
      default:                          prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/multi_waveform_dds_generator_top.sv
// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   restart_i
// out      source     out_valid_o / out_stall_i sample_o, saturated_o, last_o
// cfg      APB        psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One sample per clock unless the output stalls; a result is registered in stage 1,
// stage 2 and the output register in turn. The phase adder feeding back on the
// accumulator is the single-register loop that sets the rate; the index multiply,
// the amplitude multiply and the saturation each sit in a stage of their own.
// Reset clears state and valid flags at once; no clearing pass follows.
// A stall on the output stops only the stages that hold a beat, so empty
// stages keep taking ticks until the pipe is full.
module multi_waveform_dds_generator_top #(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned PHASE_WIDTH      = 32,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwdds_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_o,
  output logic                          saturated_o,
  output logic                          last_o
);

  localparam int unsigned DW   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned SUMW = 19;
  localparam int unsigned CW   = ((SAMPLE_WIDTH > SUMW) ? SAMPLE_WIDTH : SUMW) + 1;
  localparam logic signed [CW-1:0] SAT_HI = CW'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = SAMPLE_WIDTH'(SAT_HI);
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = SAMPLE_WIDTH'(SAT_LO);

  mwdds_pkg::cfg_t cfg;

  mwdds_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready = 1'b1;

  // Quarter-wave sine table, built at elaboration.
  logic [14:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] ANGLE =
      (mwdds_pkg::HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * SINE_TABLE_DEPTH);
    assign sine_rom[k] = mwdds_pkg::sine_entry(ANGLE);
  end

  // 32-bit registers aligned to the top of the accumulator.
  logic [PHASE_WIDTH-1:0] step_al, offset_al, chirp_al;
  logic [PHASE_WIDTH-1:0] phase_eff;
  logic [31:0]            p_top;

  if (PHASE_WIDTH >= 32) begin : g_wide
    assign step_al   = PHASE_WIDTH'(cfg.phase_step) << (PHASE_WIDTH - 32);
    assign offset_al = PHASE_WIDTH'(cfg.phase_offset) << (PHASE_WIDTH - 32);
    assign chirp_al  = PHASE_WIDTH'(cfg.chirp_step_change) << (PHASE_WIDTH - 32);
    assign p_top     = phase_eff[PHASE_WIDTH-1 -: 32];
  end else begin : g_narrow
    assign step_al   = cfg.phase_step[31 -: PHASE_WIDTH];
    assign offset_al = cfg.phase_offset[31 -: PHASE_WIDTH];
    assign chirp_al  = cfg.chirp_step_change[31 -: PHASE_WIDTH];
    assign p_top     = 32'(phase_eff) << (32 - PHASE_WIDTH);
  end

  // Pipeline handshake: each stage moves when it is empty or the next moves.
  logic s1_vld_q, s2_vld_q, out_vld_q;
  logic en1, en2, en_out, in_acc;

  assign en_out     = !out_vld_q || !out_stall_i;
  assign en2        = !s2_vld_q || en_out;
  assign en1        = !s1_vld_q || en2;
  assign in_stall_o = !en1;
  assign in_acc     = in_valid_i && en1;

  // Generator state, updated on every accepted tick.
  logic [PHASE_WIDTH-1:0] phase_acc_q, phase_acc_d;
  logic [PHASE_WIDTH-1:0] cur_step_q, cur_step_d;
  logic [PHASE_WIDTH-1:0] step_eff;
  logic [19:0]            sample_index_q, sample_index_d, sidx_eff;
  logic                   is_chirp;

  assign is_chirp = (cfg.waveform_mode == mwdds_pkg::MODE_CHIRP);

  always_comb begin
    if (restart_i) begin
      phase_eff = is_chirp ? '0 : offset_al;
      step_eff  = step_al;
      sidx_eff  = '0;
    end else begin
      phase_eff = phase_acc_q;
      step_eff  = cur_step_q;
      sidx_eff  = sample_index_q;
    end
    phase_acc_d    = phase_eff + step_eff;
    cur_step_d     = is_chirp ? step_eff + chirp_al : step_eff;
    sample_index_d = sidx_eff + 20'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_acc_q    <= '0;
      cur_step_q     <= '0;
      sample_index_q <= '0;
    end else if (in_acc) begin
      phase_acc_q    <= phase_acc_d;
      cur_step_q     <= cur_step_d;
      sample_index_q <= sample_index_d;
    end
  end

  // Stage 1 inputs: sine table index with quadrant mirroring.
  logic [30+DW:0] idx_prod;
  logic [DW-1:0]  idx_raw, idx_d;
  logic           last_d;

  assign idx_prod = 30'(p_top[29:0]) * (DW + 1)'(SINE_TABLE_DEPTH);
  assign idx_raw  = idx_prod[30 +: DW];
  assign idx_d    = p_top[30] ? DW'(SINE_TABLE_DEPTH - 1) - idx_raw : idx_raw;
  assign last_d   = ({1'b0, sidx_eff} == (cfg.sample_count - 21'd1));

  logic [DW-1:0] s1_idx_q;
  logic [15:0]   s1_p16_q;
  logic          s1_zero_q, s1_last_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_idx_q  <= idx_d;
      s1_p16_q  <= p_top[31:16];
      s1_zero_q <= (sidx_eff == 20'd0);
      s1_last_q <= last_d;
    end
  end

  // Stage 2: shape in Q1.15 (a unit level is 1 << 15), then scale.
  logic signed [16:0] shape;
  logic signed [17:0] tri_d, tri_abs, tri_v;
  logic signed [32:0] prod_d;

  always_comb begin
    tri_d   = $signed({2'b00, s1_p16_q}) * 18'sd2 - 18'sd65536;
    tri_abs = tri_d[17] ? -tri_d : tri_d;
    tri_v   = tri_abs - 18'sd32768;
    case (cfg.waveform_mode)
      mwdds_pkg::MODE_SINE,
      mwdds_pkg::MODE_CHIRP: begin
        shape = s1_p16_q[15] ? -$signed({2'b00, sine_rom[s1_idx_q]})
                             :  $signed({2'b00, sine_rom[s1_idx_q]});
      end
      mwdds_pkg::MODE_SQUARE:   shape = s1_p16_q[15] ? -17'sd32767 : 17'sd32767;
      mwdds_pkg::MODE_TRIANGLE: shape = (tri_v > 18'sd32767) ? 17'sd32767 : tri_v[16:0];
      mwdds_pkg::MODE_SAWTOOTH: shape = $signed({1'b0, s1_p16_q}) - 17'sd32768;
      mwdds_pkg::MODE_IMPULSE:  shape = s1_zero_q ? 17'sd32768 : 17'sd0;
      mwdds_pkg::MODE_DC:       shape = 17'sd32768;
      default:                  shape = 17'sd0;
    endcase
    prod_d = cfg.amplitude * shape;
  end

  logic signed [32:0] s2_prod_q;
  logic               s2_last_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_prod_q <= prod_d;
      s2_last_q <= s1_last_q;
    end
  end

  // Stage 3: floor shift, level offset and saturation.
  logic signed [SUMW-1:0]         sum;
  logic signed [CW-1:0]           sum_ext;
  logic signed [SAMPLE_WIDTH-1:0] sample_d;
  logic                           sat_d;

  always_comb begin
    sum     = SUMW'(s2_prod_q >>> 15) + SUMW'(cfg.dc_offset);
    sum_ext = CW'(sum);
    if (sum_ext > SAT_HI) begin
      sample_d = SAMPLE_MAX;
      sat_d    = 1'b1;
    end else if (sum_ext < SAT_LO) begin
      sample_d = SAMPLE_MIN;
      sat_d    = 1'b1;
    end else begin
      sample_d = sum_ext[SAMPLE_WIDTH-1:0];
      sat_d    = 1'b0;
    end
  end

  logic signed [SAMPLE_WIDTH-1:0] sample_q;
  logic                           sat_q, last_q;

  always_ff @(posedge clk_i) begin
    if (en_out) begin
      sample_q <= sample_d;
      sat_q    <= sat_d;
      last_q   <= s2_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_vld_q <= in_valid_i;
      end
      if (en2) begin
        s2_vld_q <= s1_vld_q;
      end
      if (en_out) begin
        out_vld_q <= s2_vld_q;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign sample_o    = sample_q;
  assign saturated_o = sat_q;
  assign last_o      = last_q;

  // The input only stalls when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_vld_q && s2_vld_q && out_vld_q))
    else $error("input stalled while the pipeline has room");

  a_restart_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && restart_i) |=> (sample_index_q == 20'd1))
    else $error("sample index not restarted");

  a_chirp_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && restart_i && is_chirp) |=> (phase_acc_q == $past(step_al)))
    else $error("chirp restart did not start from zero phase");

  a_step_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !restart_i && !is_chirp) |=> (cur_step_q == $past(cur_step_q)))
    else $error("step changed outside chirp mode");

  a_sat_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && sat_q) |-> (sample_q == SAMPLE_MAX || sample_q == SAMPLE_MIN))
    else $error("saturated flag without a clipped sample");

endmodule
